### design/aabb_pkg.sv
// ----------------------------------------------------------------------------
// aabb_pkg
// Operation codes, register indexes and axis helpers for the box tester.
// ----------------------------------------------------------------------------
package aabb_pkg;

  localparam int OP_W      = 3;
  localparam int REG_IDX_W = 3;

  // query operations
  localparam logic [OP_W-1:0] OP_BOX      = 3'd0;
  localparam logic [OP_W-1:0] OP_SPHERE   = 3'd1;
  localparam logic [OP_W-1:0] OP_PLANE    = 3'd2;
  localparam logic [OP_W-1:0] OP_TRIANGLE = 3'd3;
  localparam logic [OP_W-1:0] OP_POINT    = 3'd4;
  localparam logic [OP_W-1:0] OP_NEAREST  = 3'd5;

  // configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_BOX_MIN_X = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_BOX_MIN_Y = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_BOX_MIN_Z = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_BOX_MAX_X = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_BOX_MAX_Y = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_BOX_MAX_Z = 3'd5;

  // cyclic axis neighbors: next and previous of x, y, z
  localparam int AX_NEXT [3] = '{1, 2, 0};
  localparam int AX_PREV [3] = '{2, 0, 1};

endpackage

### design/aabb_collision_tester_unit.sv
// ----------------------------------------------------------------------------
// aabb_collision_tester_unit
// Exact fixed-point intersection tests of one query against a configured
// axis-aligned box: box, sphere, plane, triangle (13-axis SAT), strict
// point containment and nearest point.
// ----------------------------------------------------------------------------
// Pipeline: eight register stages, stage1 to stage7 and the result register;
//   a result waits in the result register while the result side stalls.
// Throughput: one request per cycle unless the result side stalls; each stage
//   holds or advances on its own, so bubbles close up behind a stalled result.
// Reset: synchronous rst clears all stage valid bits and the box registers.
// ----------------------------------------------------------------------------
module aabb_collision_tester_unit
  import aabb_pkg::*;
#(
  parameter int COORD_WIDTH   = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          cfg_write_enable,
  input  logic [REG_IDX_W-1:0]          cfg_index,
  input  logic signed [COORD_WIDTH-1:0] cfg_data,
  // query channel
  input  logic                          query_valid,
  output logic                          query_stall,
  input  logic [OP_W-1:0]               operation,
  input  logic signed [COORD_WIDTH-1:0] first_x,
  input  logic signed [COORD_WIDTH-1:0] first_y,
  input  logic signed [COORD_WIDTH-1:0] first_z,
  input  logic signed [COORD_WIDTH-1:0] second_x,
  input  logic signed [COORD_WIDTH-1:0] second_y,
  input  logic signed [COORD_WIDTH-1:0] second_z,
  input  logic signed [COORD_WIDTH-1:0] third_x,
  input  logic signed [COORD_WIDTH-1:0] third_y,
  input  logic signed [COORD_WIDTH-1:0] third_z,
  input  logic signed [COORD_WIDTH-1:0] scalar_operand,
  // result channel
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic                          hit,
  output logic signed [COORD_WIDTH-1:0] nearest_x,
  output logic signed [COORD_WIDTH-1:0] nearest_y,
  output logic signed [COORD_WIDTH-1:0] nearest_z
);

  localparam int W   = COORD_WIDTH;
  localparam int EW  = W + 1;            // extent and hi+lo
  localparam int VW  = W + 2;            // doubled, centered vertex
  localparam int FW  = W + 3;            // edge vector
  localparam int SW  = 2 * W + 4;        // sphere distance sum
  localparam int PLW = (2 * W + 4 > W + FRACTION_BITS + 3) ? 2 * W + 4
                                                           : W + FRACTION_BITS + 3;
  localparam int PJ  = 2 * W + 6;        // edge axis projection
  localparam int NW  = 2 * FW + 1;       // triangle normal component
  localparam int NH  = NW / 2;           // low slice of the normal
  localparam int NU  = NW - NH;          // high slice of the normal
  localparam int TW  = 3 * W + 10;       // normal projection
  localparam int NST = 8;

  typedef struct {
    logic [OP_W-1:0]      op;
    logic                 box_hit;
    logic                 point_hit;
    logic signed [W-1:0]  nearest [3];
  } cmn_t;

  typedef struct {
    cmn_t                 cm;
    logic signed [VW-1:0] v [3][3];
    logic signed [EW-1:0] e2 [3];
    logic signed [EW-1:0] hl [3];
    logic signed [W-1:0]  nrm [3];
    logic signed [W-1:0]  s;
    logic signed [EW-1:0] d [3];
  } s1_t;

  typedef struct {
    cmn_t                      cm;
    logic signed [VW-1:0]      v [3][3];
    logic signed [EW-1:0]      e2 [3];
    logic signed [FW-1:0]      f [3][3];
    logic                      unit_sep;
    logic signed [2*W+1:0]     d2 [3];
    logic signed [2*W-1:0]     s_sq;
    logic                      s_neg;
    logic signed [2*W+1:0]     pl_r [3];
    logic signed [2*W:0]       pl_t [3];
    logic signed [W-1:0]       s;
  } s2_t;

  typedef struct {
    cmn_t                      cm;
    logic                      sph_hit;
    logic                      unit_sep;
    logic signed [PLW-1:0]     pl_t_sum;
    logic signed [PLW-1:0]     pl_r_sum;
    logic signed [VW+FW-1:0]   pj_a [9][3];
    logic signed [VW+FW-1:0]   pj_b [9][3];
    logic signed [EW+FW:0]     rd_a [9];
    logic signed [EW+FW:0]     rd_b [9];
    logic signed [2*FW-1:0]    cr_a [3];
    logic signed [2*FW-1:0]    cr_b [3];
    logic signed [VW-1:0]      v0 [3];
    logic signed [EW-1:0]      e2 [3];
  } s3_t;

  typedef struct {
    cmn_t                      cm;
    logic                      sph_hit;
    logic                      unit_sep;
    logic                      pl_hit;
    logic signed [PJ-1:0]      proj [9][3];
    logic signed [PJ-1:0]      rad [9];
    logic signed [NW-1:0]      nrm [3];
    logic signed [VW-1:0]      v0 [3];
    logic signed [EW-1:0]      e2 [3];
  } s4_t;

  typedef struct {
    cmn_t                      cm;
    logic                      sph_hit;
    logic                      pl_hit;
    logic                      tri_sep;
    logic signed [VW+NU-1:0]   pn_h [3];
    logic signed [VW+NH:0]     pn_l [3];
    logic signed [EW+NU:0]     rn_h [3];
    logic signed [EW+NH:0]     rn_l [3];
  } s5_t;

  typedef struct {
    cmn_t                      cm;
    logic                      sph_hit;
    logic                      pl_hit;
    logic                      tri_sep;
    logic signed [TW-1:0]      pn [3];
    logic signed [TW-1:0]      rn [3];
  } s6_t;

  typedef struct {
    cmn_t                      cm;
    logic                      sph_hit;
    logic                      pl_hit;
    logic                      tri_sep;
    logic signed [TW-1:0]      p_sum;
    logic signed [TW-1:0]      r_sum;
  } s7_t;

  logic signed [W-1:0] box_lo [3];
  logic signed [W-1:0] box_hi [3];
  logic signed [W-1:0] pt [3][3];

  logic [NST:1] vld;
  logic [NST:1] en;

  s1_t stage1, stage1_next;
  s2_t stage2, stage2_next;
  s3_t stage3, stage3_next;
  s4_t stage4, stage4_next;
  s5_t stage5, stage5_next;
  s6_t stage6, stage6_next;
  s7_t stage7;
  s7_t stage7_next;
  logic               hit_next;
  logic signed [W-1:0] nearest_next [3];

  // box registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 3; k++) begin
        box_lo[k] <= '0;
        box_hi[k] <= '0;
      end
    end else if (cfg_write_enable) begin
      case (cfg_index)
        REG_BOX_MIN_X: box_lo[0] <= cfg_data;
        REG_BOX_MIN_Y: box_lo[1] <= cfg_data;
        REG_BOX_MIN_Z: box_lo[2] <= cfg_data;
        REG_BOX_MAX_X: box_hi[0] <= cfg_data;
        REG_BOX_MAX_Y: box_hi[1] <= cfg_data;
        REG_BOX_MAX_Z: box_hi[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign pt[0][0] = first_x;
  assign pt[0][1] = first_y;
  assign pt[0][2] = first_z;
  assign pt[1][0] = second_x;
  assign pt[1][1] = second_y;
  assign pt[1][2] = second_z;
  assign pt[2][0] = third_x;
  assign pt[2][1] = third_y;
  assign pt[2][2] = third_z;

  // stage flow: a stage loads when it is empty or the next one loads
  always_comb begin
    en[NST] = !vld[NST] || !result_stall;
    for (int i = NST - 1; i >= 1; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign query_stall  = !en[1];
  assign result_valid = vld[NST];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) vld[1] <= query_valid;
      for (int i = 2; i <= NST; i++) begin
        if (en[i]) vld[i] <= vld[i-1];
      end
    end
  end

  // stage 1: centering, extents, clamp and the simple tests
  always_comb begin
    logic signed [W-1:0] clamp_t;
    logic signed [W-1:0] clamp_c;
    stage1_next.cm.op        = operation;
    stage1_next.cm.box_hit   = 1'b1;
    stage1_next.cm.point_hit = 1'b1;
    stage1_next.s            = scalar_operand;
    for (int k = 0; k < 3; k++) begin
      stage1_next.e2[k]  = EW'(box_hi[k]) - EW'(box_lo[k]);
      stage1_next.hl[k]  = EW'(box_hi[k]) + EW'(box_lo[k]);
      stage1_next.nrm[k] = pt[0][k];
      for (int j = 0; j < 3; j++) begin
        stage1_next.v[j][k] = (VW'(pt[j][k]) <<< 1)
                            - (VW'(box_hi[k]) + VW'(box_lo[k]));
      end
      clamp_t = (pt[0][k] < box_hi[k]) ? pt[0][k] : box_hi[k];
      clamp_c = (box_lo[k] > clamp_t) ? box_lo[k] : clamp_t;
      stage1_next.cm.nearest[k] = clamp_c;
      stage1_next.d[k] = EW'(pt[0][k]) - EW'(clamp_c);
      if (!(box_lo[k] <= pt[1][k] && box_hi[k] >= pt[0][k])) begin
        stage1_next.cm.box_hit = 1'b0;
      end
      if (!(pt[0][k] > box_lo[k] && pt[0][k] < box_hi[k])) begin
        stage1_next.cm.point_hit = 1'b0;
      end
    end
  end

  // stage 2: edges, unit axes, sphere and plane products
  always_comb begin
    logic signed [VW:0] umax;
    logic signed [VW:0] umin;
    logic signed [VW:0] ufar;
    logic signed [W:0]  an;
    stage2_next.cm       = stage1.cm;
    stage2_next.v        = stage1.v;
    stage2_next.e2       = stage1.e2;
    stage2_next.s        = stage1.s;
    stage2_next.s_neg    = stage1.s < 0;
    stage2_next.s_sq     = stage1.s * stage1.s;
    stage2_next.unit_sep = 1'b0;
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        stage2_next.f[i][k] = FW'(stage1.v[AX_NEXT[i]][k]) - FW'(stage1.v[i][k]);
      end
    end
    for (int k = 0; k < 3; k++) begin
      umax = (VW+1)'(stage1.v[0][k]);
      umin = (VW+1)'(stage1.v[0][k]);
      for (int j = 1; j < 3; j++) begin
        if ((VW+1)'(stage1.v[j][k]) > umax) umax = (VW+1)'(stage1.v[j][k]);
        if ((VW+1)'(stage1.v[j][k]) < umin) umin = (VW+1)'(stage1.v[j][k]);
      end
      ufar = (-umax > umin) ? -umax : umin;
      if (ufar > (VW+1)'(stage1.e2[k])) stage2_next.unit_sep = 1'b1;
      stage2_next.d2[k] = stage1.d[k] * stage1.d[k];
      an = (stage1.nrm[k] < 0) ? -(W+1)'(stage1.nrm[k]) : (W+1)'(stage1.nrm[k]);
      stage2_next.pl_r[k] = stage1.e2[k] * an;
      stage2_next.pl_t[k] = stage1.nrm[k] * stage1.hl[k];
    end
  end

  // stage 3: edge-axis and normal products, sphere and plane sums
  always_comb begin
    logic signed [SW-1:0] dsum;
    logic signed [FW:0]   af1;
    logic signed [FW:0]   af2;
    int k1;
    int k2;
    stage3_next.cm       = stage2.cm;
    stage3_next.unit_sep = stage2.unit_sep;
    stage3_next.e2       = stage2.e2;
    dsum = SW'(stage2.d2[0]) + SW'(stage2.d2[1]) + SW'(stage2.d2[2]);
    stage3_next.sph_hit = !stage2.s_neg && (dsum <= SW'(stage2.s_sq));
    stage3_next.pl_t_sum = PLW'(stage2.pl_t[0]) + PLW'(stage2.pl_t[1])
                         + PLW'(stage2.pl_t[2])
                         - (PLW'(stage2.s) <<< (FRACTION_BITS + 1));
    stage3_next.pl_r_sum = PLW'(stage2.pl_r[0]) + PLW'(stage2.pl_r[1])
                         + PLW'(stage2.pl_r[2]);
    for (int k = 0; k < 3; k++) begin
      k1 = AX_NEXT[k];
      k2 = AX_PREV[k];
      stage3_next.v0[k]   = stage2.v[0][k];
      stage3_next.cr_a[k] = stage2.f[0][k1] * stage2.f[1][k2];
      stage3_next.cr_b[k] = stage2.f[0][k2] * stage2.f[1][k1];
      // axis u_k x f_i has component k1 = -f[k2] and k2 = f[k1]
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          stage3_next.pj_a[k*3+i][j] = stage2.v[j][k2] * stage2.f[i][k1];
          stage3_next.pj_b[k*3+i][j] = stage2.v[j][k1] * stage2.f[i][k2];
        end
        af1 = (stage2.f[i][k1] < 0) ? -(FW+1)'(stage2.f[i][k1]) : (FW+1)'(stage2.f[i][k1]);
        af2 = (stage2.f[i][k2] < 0) ? -(FW+1)'(stage2.f[i][k2]) : (FW+1)'(stage2.f[i][k2]);
        stage3_next.rd_a[k*3+i] = stage2.e2[k1] * af2;
        stage3_next.rd_b[k*3+i] = stage2.e2[k2] * af1;
      end
    end
  end

  // stage 4: projections, radii, normal and the plane compare
  always_comb begin
    logic signed [PLW:0] at;
    stage4_next.cm       = stage3.cm;
    stage4_next.sph_hit  = stage3.sph_hit;
    stage4_next.unit_sep = stage3.unit_sep;
    stage4_next.v0       = stage3.v0;
    stage4_next.e2       = stage3.e2;
    at = (stage3.pl_t_sum < 0) ? -(PLW+1)'(stage3.pl_t_sum) : (PLW+1)'(stage3.pl_t_sum);
    stage4_next.pl_hit = at <= (PLW+1)'(stage3.pl_r_sum);
    for (int a = 0; a < 9; a++) begin
      for (int j = 0; j < 3; j++) begin
        stage4_next.proj[a][j] = PJ'(stage3.pj_a[a][j]) - PJ'(stage3.pj_b[a][j]);
      end
      stage4_next.rad[a] = PJ'(stage3.rd_a[a]) + PJ'(stage3.rd_b[a]);
    end
    for (int k = 0; k < 3; k++) begin
      stage4_next.nrm[k] = NW'(stage3.cr_a[k]) - NW'(stage3.cr_b[k]);
    end
  end

  // stage 5: edge-axis separation, split products for the normal axis
  always_comb begin
    logic signed [PJ:0]   pmax;
    logic signed [PJ:0]   pmin;
    logic signed [PJ:0]   pfar;
    logic [NW-1:0]        an;
    logic signed [NU-1:0] nh;
    logic signed [NH:0]   nl;
    logic signed [NU:0]   anh;
    logic signed [NH:0]   anl;
    stage5_next.cm      = stage4.cm;
    stage5_next.sph_hit = stage4.sph_hit;
    stage5_next.pl_hit  = stage4.pl_hit;
    stage5_next.tri_sep = stage4.unit_sep;
    for (int a = 0; a < 9; a++) begin
      pmax = (PJ+1)'(stage4.proj[a][0]);
      pmin = (PJ+1)'(stage4.proj[a][0]);
      for (int j = 1; j < 3; j++) begin
        if ((PJ+1)'(stage4.proj[a][j]) > pmax) pmax = (PJ+1)'(stage4.proj[a][j]);
        if ((PJ+1)'(stage4.proj[a][j]) < pmin) pmin = (PJ+1)'(stage4.proj[a][j]);
      end
      pfar = (-pmax > pmin) ? -pmax : pmin;
      if (pfar > (PJ+1)'(stage4.rad[a])) stage5_next.tri_sep = 1'b1;
    end
    // all vertices share one projection on the normal, vertex A is used
    for (int k = 0; k < 3; k++) begin
      nh  = $signed(stage4.nrm[k][NW-1:NH]);
      nl  = $signed({1'b0, stage4.nrm[k][NH-1:0]});
      an  = (stage4.nrm[k] < 0) ? NW'(-stage4.nrm[k]) : NW'(stage4.nrm[k]);
      anh = $signed({1'b0, an[NW-1:NH]});
      anl = $signed({1'b0, an[NH-1:0]});
      stage5_next.pn_h[k] = stage4.v0[k] * nh;
      stage5_next.pn_l[k] = stage4.v0[k] * nl;
      stage5_next.rn_h[k] = stage4.e2[k] * anh;
      stage5_next.rn_l[k] = stage4.e2[k] * anl;
    end
  end

  // stage 6: join the split products
  always_comb begin
    stage6_next.cm      = stage5.cm;
    stage6_next.sph_hit = stage5.sph_hit;
    stage6_next.pl_hit  = stage5.pl_hit;
    stage6_next.tri_sep = stage5.tri_sep;
    for (int k = 0; k < 3; k++) begin
      stage6_next.pn[k] = (TW'(stage5.pn_h[k]) <<< NH) + TW'(stage5.pn_l[k]);
      stage6_next.rn[k] = (TW'(stage5.rn_h[k]) <<< NH) + TW'(stage5.rn_l[k]);
    end
  end

  // stage 7: normal projection and radius
  always_comb begin
    stage7_next.cm      = stage6.cm;
    stage7_next.sph_hit = stage6.sph_hit;
    stage7_next.pl_hit  = stage6.pl_hit;
    stage7_next.tri_sep = stage6.tri_sep;
    stage7_next.p_sum   = stage6.pn[0] + stage6.pn[1] + stage6.pn[2];
    stage7_next.r_sum   = stage6.rn[0] + stage6.rn[1] + stage6.rn[2];
  end

  // stage 8: normal compare and result select
  always_comb begin
    logic signed [TW-1:0] ap;
    logic                 tri_hit;
    ap = (stage7.p_sum < 0) ? -stage7.p_sum : stage7.p_sum;
    tri_hit = !stage7.tri_sep && !(ap > stage7.r_sum);
    case (stage7.cm.op)
      OP_BOX:      hit_next = stage7.cm.box_hit;
      OP_SPHERE:   hit_next = stage7.sph_hit;
      OP_PLANE:    hit_next = stage7.pl_hit;
      OP_TRIANGLE: hit_next = tri_hit;
      OP_POINT:    hit_next = stage7.cm.point_hit;
      default:     hit_next = 1'b0;
    endcase
    for (int k = 0; k < 3; k++) begin
      nearest_next[k] = (stage7.cm.op == OP_NEAREST) ? stage7.cm.nearest[k] : '0;
    end
  end

  // stage payload registers
  always_ff @(posedge clk) begin
    if (en[1]) stage1 <= stage1_next;
    if (en[2]) stage2 <= stage2_next;
    if (en[3]) stage3 <= stage3_next;
    if (en[4]) stage4 <= stage4_next;
    if (en[5]) stage5 <= stage5_next;
    if (en[6]) stage6 <= stage6_next;
    if (en[7]) stage7 <= stage7_next;
    if (en[8]) begin
      hit       <= hit_next;
      nearest_x <= nearest_next[0];
      nearest_y <= nearest_next[1];
      nearest_z <= nearest_next[2];
    end
  end

  // checks
  logic req_take;
  logic res_take;
  assign req_take = query_valid && !query_stall;
  assign res_take = result_valid && !result_stall;

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    query_stall |-> (&vld))
    else $error("request stalled while the pipeline has a free stage");

  a_count: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> $countones(vld) == $past($countones(vld)) + int'($past(req_take))
                                - int'($past(res_take)))
    else $error("request count in the pipeline went wrong");

  a_nearest_no_hit: assert property (@(posedge clk) disable iff (rst)
    result_valid && (nearest_x != 0 || nearest_y != 0 || nearest_z != 0) |-> !hit)
    else $error("nearest point result carries a hit");

  a_reset_empty: assert property (@(posedge clk)
    !rst && $past(rst) |-> !result_valid)
    else $error("result valid right after reset");

endmodule
